FILE: hdl/hslp_pkg.sv
`timescale 1ns / 1ps
package hslp_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_BITS_DEF = 12;
  localparam int SIZE_BITS      = 13;
  localparam int SAT_BITS       = 16;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [SIZE_BITS-1:0] WIDTH_RST  = 13'd256;
  localparam logic [SIZE_BITS-1:0] HEIGHT_RST = 13'd256;
  localparam logic [SAT_BITS-1:0]  SAT_RST    = 16'd64881;

  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SAT    = 2'd2;

  // clamped coordinate pair, both below their divisor
  typedef struct packed {
    logic [SIZE_BITS-1:0] x;
    logic [SIZE_BITS-1:0] y;
  } hslp_coord_t;

  // a size of zero behaves as one
  function automatic logic [SIZE_BITS-1:0] size_fix(input logic [SIZE_BITS-1:0] s);
    size_fix = (s == '0) ? SIZE_BITS'(1) : s;
  endfunction

endpackage

FILE: hdl/hslp_front.sv
`timescale 1ns / 1ps
module hslp_front #(
  parameter int COORD_BITS = hslp_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [COORD_BITS-1:0]          pixel_x_i,
  input  logic [COORD_BITS-1:0]          pixel_y_i,
  input  logic [hslp_pkg::SIZE_BITS-1:0] width_i,
  input  logic [hslp_pkg::SIZE_BITS-1:0] height_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output hslp_pkg::hslp_coord_t          push_data_o
);
  import hslp_pkg::*;

  localparam int MW = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;

  logic        valid_q, valid_d;
  hslp_coord_t data_q, data_d;
  logic        ready;
  logic [MW-1:0] xe, ye, we, he;

  assign ready  = !valid_q || !q_full_i;
  assign busy   = !ready;
  assign push_o = valid_q && !q_full_i;
  assign push_data_o = data_q;

  always_comb begin
    we = MW'(size_fix(width_i));
    he = MW'(size_fix(height_i));
    xe = MW'(pixel_x_i);
    ye = MW'(pixel_y_i);
    data_d = data_q;
    valid_d = valid_q;
    if (push_o) valid_d = 1'b0;
    if (start && ready) begin
      valid_d = 1'b1;
      data_d.x = (xe >= we) ? SIZE_BITS'(we - MW'(1)) : SIZE_BITS'(xe);
      data_d.y = (ye >= he) ? SIZE_BITS'(he - MW'(1)) : SIZE_BITS'(ye);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

FILE: hdl/hslp_queue.sv
`timescale 1ns / 1ps
module hslp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  hslp_pkg::hslp_coord_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output hslp_pkg::hslp_coord_t pop_data_o
);
  import hslp_pkg::*;

  hslp_coord_t mem_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

endmodule

FILE: hdl/hslp_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage. num_i < den_i is required,
// so the quotient is a pure fraction of QB bits.
module hslp_div #(
  parameter int QB = hslp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic [hslp_pkg::SIZE_BITS-1:0] num_i,
  input  logic [hslp_pkg::SIZE_BITS-1:0] den_i,
  output logic [QB-1:0]                  quo_o
);
  import hslp_pkg::*;

  logic [SIZE_BITS-1:0] rem_q [QB];
  logic [SIZE_BITS-1:0] den_q [QB];
  logic [QB-1:0]        quo_q [QB];

  logic [SIZE_BITS-1:0] rem_in [QB];
  logic [SIZE_BITS-1:0] den_in [QB];
  logic [QB-1:0]        quo_in [QB];
  logic [SIZE_BITS:0]   sh [QB];
  logic                 ge [QB];

  always_comb begin
    for (int i = 0; i < QB; i++) begin
      rem_in[i] = (i == 0) ? num_i : rem_q[(i == 0) ? 0 : i-1];
      den_in[i] = (i == 0) ? den_i : den_q[(i == 0) ? 0 : i-1];
      quo_in[i] = (i == 0) ? '0 : quo_q[(i == 0) ? 0 : i-1];
      sh[i] = {rem_in[i], 1'b0};
      ge[i] = (sh[i] >= {1'b0, den_in[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QB; i++) begin
      rem_q[i] <= ge[i] ? SIZE_BITS'(sh[i] - {1'b0, den_in[i]}) : SIZE_BITS'(sh[i]);
      den_q[i] <= den_in[i];
      quo_q[i] <= {quo_in[i][QB-2:0], ge[i]};
    end
  end

  assign quo_o = quo_q[QB-1];

endmodule

FILE: hdl/hslp_back.sv
`timescale 1ns / 1ps
module hslp_back #(
  parameter int FRAC_BITS = hslp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  output logic                           pop_o,
  input  hslp_pkg::hslp_coord_t          pop_data_i,
  input  logic [hslp_pkg::SIZE_BITS-1:0] width_i,
  input  logic [hslp_pkg::SIZE_BITS-1:0] height_i,
  input  logic [hslp_pkg::SAT_BITS-1:0]  sat_i,
  output logic                           result_valid_o,
  output logic [7:0]                     red_o,
  output logic [7:0]                     green_o,
  output logic [7:0]                     blue_o,
  output logic [15:0]                    packed_4444_o
);
  import hslp_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int FW  = F + 1;
  localparam int MB  = FW + 3;
  localparam int LAT = F + 6;

  localparam logic [FW-1:0] ONE        = FW'(1) << F;
  localparam logic [FW-1:0] HALF       = ONE / 2;
  localparam logic [FW-1:0] THIRD      = ONE / 3;
  localparam logic [FW-1:0] SIXTH      = ONE / 6;
  localparam logic [FW-1:0] TWO_THIRDS = (2 * ONE) / 3;

  localparam logic [1:0] RAMP_UP   = 2'd0;
  localparam logic [1:0] RAMP_Q    = 2'd1;
  localparam logic [1:0] RAMP_DOWN = 2'd2;
  localparam logic [1:0] RAMP_P    = 2'd3;

  logic [LAT-1:0] vp_q;
  logic [F-1:0]   hue_quo, lum_quo, satf;

  assign pop_o = !q_empty_i;

  hslp_div #(.QB(F)) u_div_hue (
    .clk_i (clk_i),
    .num_i (pop_data_i.x),
    .den_i (size_fix(width_i)),
    .quo_o (hue_quo)
  );

  hslp_div #(.QB(F)) u_div_lum (
    .clk_i (clk_i),
    .num_i (pop_data_i.y),
    .den_i (size_fix(height_i)),
    .quo_o (lum_quo)
  );

  if (F >= SAT_BITS) begin : g_sat_up
    assign satf = F'(sat_i) << (F - SAT_BITS);
  end else begin : g_sat_dn
    assign satf = F'(sat_i >> (SAT_BITS - F));
  end

  // stage A: products for Q
  logic [F-1:0]    a_hue_q;
  logic [FW-1:0]   a_lum_q;
  logic [F-1:0]    a_sat_q;
  logic [2*FW-1:0] a_m1_q;
  logic [FW+F-1:0] a_m2_q;
  logic [FW-1:0]   lum;

  assign lum = ONE - FW'(lum_quo);

  always_ff @(posedge clk_i) begin
    a_hue_q <= hue_quo;
    a_lum_q <= lum;
    a_sat_q <= satf;
    a_m1_q  <= (2*FW)'(lum) * (2*FW)'(ONE + FW'(satf));
    a_m2_q  <= (FW+F)'(lum) * (FW+F)'(satf);
  end

  // stage B: Q and P
  logic [F-1:0]  b_hue_q;
  logic [FW-1:0] b_q_q, b_p_q;
  logic [FW-1:0] qv;
  logic [FW:0]   qs;
  logic [FW+1:0] pd;

  always_comb begin
    qs = (FW+1)'(a_lum_q) + (FW+1)'(a_sat_q) - (FW+1)'(a_m2_q[F +: FW]);
    qv = (a_lum_q < HALF) ? a_m1_q[F +: FW] : FW'(qs);
    pd = (FW+2)'({a_lum_q, 1'b0}) - (FW+2)'(qv);
  end

  always_ff @(posedge clk_i) begin
    b_hue_q <= a_hue_q;
    b_q_q   <= qv;
    b_p_q   <= pd[FW+1] ? '0 : FW'(pd);
  end

  // stage C: hue offsets, arm select, ramp slope factor
  logic [1:0]    c_sel_q [3];
  logic [MB-1:0] c_m_q   [3];
  logic [FW-1:0] c_p_q, c_q_q, c_span_q;
  logic [FW-1:0] t [3];
  logic [FW:0]   tr;
  logic [1:0]    sel [3];
  logic [MB-1:0] mf  [3];

  always_comb begin
    tr   = (FW+1)'(b_hue_q) + (FW+1)'(THIRD);
    t[0] = (tr > (FW+1)'(ONE)) ? FW'(tr - (FW+1)'(ONE)) : FW'(tr);
    t[1] = FW'(b_hue_q);
    t[2] = (FW'(b_hue_q) < THIRD) ? FW'(b_hue_q) + ONE - THIRD : FW'(b_hue_q) - THIRD;
    for (int c = 0; c < 3; c++) begin
      if (t[c] < SIXTH) begin
        sel[c] = RAMP_UP;
        mf[c]  = MB'(t[c]) * MB'(6);
      end else if (t[c] < HALF) begin
        sel[c] = RAMP_Q;
        mf[c]  = '0;
      end else if (t[c] < TWO_THIRDS) begin
        sel[c] = RAMP_DOWN;
        mf[c]  = MB'(TWO_THIRDS - t[c]) * MB'(6);
      end else begin
        sel[c] = RAMP_P;
        mf[c]  = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      c_sel_q[c] <= sel[c];
      c_m_q[c]   <= mf[c];
    end
    c_p_q    <= b_p_q;
    c_q_q    <= b_q_q;
    c_span_q <= b_q_q - b_p_q;
  end

  // stage D: span times slope
  logic [1:0]       d_sel_q [3];
  logic [FW+MB-1:0] d_pr_q  [3];
  logic [FW-1:0]    d_p_q, d_q_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      d_sel_q[c] <= c_sel_q[c];
      d_pr_q[c]  <= (FW+MB)'(c_span_q) * (FW+MB)'(c_m_q[c]);
    end
    d_p_q <= c_p_q;
    d_q_q <= c_q_q;
  end

  // stage E: ramp value, clamped to one
  logic [FW-1:0] e_v_q [3];
  logic [FW-1:0] ev [3];
  logic [MB:0]   rs [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rs[c] = (MB+1)'(d_p_q) + (MB+1)'(d_pr_q[c][F +: MB]);
      case (d_sel_q[c])
        RAMP_UP, RAMP_DOWN: ev[c] = (rs[c] > (MB+1)'(ONE)) ? ONE : FW'(rs[c]);
        RAMP_Q:             ev[c] = d_q_q;
        default:            ev[c] = d_p_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) e_v_q[c] <= ev[c];
  end

  // stage F: scale to a byte, truncated
  logic [FW+7:0] sc [3];
  logic [7:0]    by [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sc[c] = (FW+8)'(e_v_q[c]) * (FW+8)'(255);
      by[c] = sc[c][F +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    red_o         <= by[0];
    green_o       <= by[1];
    blue_o        <= by[2];
    packed_4444_o <= {4'hF, by[0][7:4], by[1][7:4], by[2][7:4]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= '0;
    end else begin
      vp_q <= {vp_q[LAT-2:0], pop_o};
    end
  end

  assign result_valid_o = vp_q[LAT-1];

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(pop_o, LAT)) else $error("result without matching pop");
  a_nibble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (packed_4444_o[15:12] == 4'hF)) else $error("bad packed top nibble");
  a_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (packed_4444_o[11:8] == red_o[7:4]))
    else $error("packed red mismatch");

endmodule

FILE: hdl/hsl_picker_pixel_to_rgb.sv
`timescale 1ns / 1ps
// channel  direction  handshake                     payload
// cmd      in         start, busy                   pixel_x_i, pixel_y_i
// cfg      in         cfg_valid_i, cfg_ready_o      cfg_index_i, cfg_data_i
// result   out        result_valid_o (strobe)       red_o, green_o, blue_o, packed_4444_o
//
// One pixel per clock sustained while busy is low. From start to strobe the path runs through the
// front register, queue, FRAC_BITS restoring divider stages and six math stages.
// Reset is asynchronous, active low; config regs return to 256 / 256 / 64881.
// The result strobe cannot be held off; busy rises only if the queue fills.
module hsl_picker_pixel_to_rgb #(
  parameter int FRAC_BITS  = hslp_pkg::FRAC_BITS_DEF,
  parameter int COORD_BITS = hslp_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [COORD_BITS-1:0]             pixel_x_i,
  input  logic [COORD_BITS-1:0]             pixel_y_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [hslp_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [15:0]                       cfg_data_i,
  output logic                              result_valid_o,
  output logic [7:0]                        red_o,
  output logic [7:0]                        green_o,
  output logic [7:0]                        blue_o,
  output logic [15:0]                       packed_4444_o
);
  import hslp_pkg::*;

  logic [SIZE_BITS-1:0] width_q, height_q;
  logic [SAT_BITS-1:0]  sat_q;
  logic                 push, full, pop, empty;
  hslp_coord_t          push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      sat_q    <= SAT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i[SIZE_BITS-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[SIZE_BITS-1:0];
        REG_SAT:    sat_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hslp_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .width_i     (width_q),
    .height_i    (height_q),
    .q_full_i    (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  hslp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  hslp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (empty),
    .pop_o          (pop),
    .pop_data_i     (pop_data),
    .width_i        (width_q),
    .height_i       (height_q),
    .sat_i          (sat_q),
    .result_valid_o (result_valid_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .packed_4444_o  (packed_4444_o)
  );

endmodule
